### rtl/chgc_pkg.sv
`timescale 1ns / 1ps
package chgc_pkg;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_PUSH  = 2'd2;
	localparam logic [1:0] REQ_POP   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
	localparam logic [1:0] ST_ROOT_ERR  = 2'd3;

	// pointer word: tag 2'b10 in bits 31:30, cell index below
	localparam logic [1:0] PTR_TAG = 2'b10;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] head_word;
		logic [31:0] tail_word;
		logic [31:0] ref_word;
		logic        which_half;
	} in_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic [1:0]  status;
	} out_t;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_CAPTURE,
		CMD_RD_DONE,
		CMD_PUSH,
		CMD_POP_RD,
		CMD_POP_DONE,
		CMD_AL_PICK,
		CMD_AL_FREE,
		CMD_AL_WRITE,
		CMD_GC_START,
		CMD_CLR,
		CMD_ROOT_RD,
		CMD_ROOT_LD,
		CMD_V_RD,
		CMD_V_ACT,
		CMD_T_POP,
		CMD_T_CELL,
		CMD_T_HEAD,
		CMD_T_TAIL,
		CMD_S_RD,
		CMD_S_ACT,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fc_nz;
		logic cu_lt;
		logic rc_nz;
		logic j_lt_rc;
		logic i_last;
		logic wl_nz;
		logic ovf;
		logic out_free;
	} sts_t;

endpackage

### rtl/cons_heap_mark_sweep_gc.sv
`timescale 1ns / 1ps
// One item in flight; the next is taken the cycle after its beat is registered. An
// allocate that finds or leaves the heap full runs a collection: it clears every mark,
// visits each root and each marked cell, then sweeps every cell, all through
// single-port memory steps. arst_n clears counts, marks need no pass: every
// collection clears them first.
module cons_heap_mark_sweep_gc #(
	parameter int HEAP_DEPTH     = 256,
	parameter int ROOT_DEPTH     = 64,
	parameter int WORKLIST_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  chgc_pkg::in_t     in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output chgc_pkg::out_t    out_data
);

	chgc_pkg::cmd_t cmd;
	chgc_pkg::sts_t sts;

	chgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (in_data.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	chgc_dp #(
		.HEAP_DEPTH     (HEAP_DEPTH),
		.ROOT_DEPTH     (ROOT_DEPTH),
		.WORKLIST_DEPTH (WORKLIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### rtl/chgc_ctrl.sv
`timescale 1ns / 1ps
module chgc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  chgc_pkg::sts_t    sts,
	output chgc_pkg::cmd_t    cmd
);

	typedef enum logic [22:0] {
		S_IDLE  = 23'h000001,
		S_RD    = 23'h000002,
		S_PUSH  = 23'h000004,
		S_POP   = 23'h000008,
		S_POPD  = 23'h000010,
		S_APICK = 23'h000020,
		S_AFREE = 23'h000040,
		S_AWR   = 23'h000080,
		S_APOST = 23'h000100,
		S_GSTRT = 23'h000200,
		S_GCLR  = 23'h000400,
		S_GROOT = 23'h000800,
		S_GRLD  = 23'h001000,
		S_VRD   = 23'h002000,
		S_VACT  = 23'h004000,
		S_TPOP  = 23'h008000,
		S_TCELL = 23'h010000,
		S_THEAD = 23'h020000,
		S_TTAIL = 23'h040000,
		S_SRD   = 23'h080000,
		S_SACT  = 23'h100000,
		S_FIN   = 23'h200000,
		S_GEND  = 23'h400000
	} state_t;

	state_t state_q, state_d, vret_q, vret_d;
	logic has_new_q, has_new_d, post_q, post_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		vret_d    = vret_q;
		has_new_d = has_new_q;
		post_d    = post_q;
		cmd       = chgc_pkg::CMD_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = chgc_pkg::CMD_CAPTURE;
					unique case (req_type)
						chgc_pkg::REQ_ALLOC: begin
							if (sts.full) begin
								has_new_d = 1'b0;
								post_d    = 1'b0;
								state_d   = S_GSTRT;
							end else begin
								state_d = S_APICK;
							end
						end
						chgc_pkg::REQ_READ: state_d = S_RD;
						chgc_pkg::REQ_PUSH: state_d = S_PUSH;
						default:            state_d = S_POP;
					endcase
				end
			end
			S_RD: begin
				cmd     = chgc_pkg::CMD_RD_DONE;
				state_d = S_FIN;
			end
			S_PUSH: begin
				cmd     = chgc_pkg::CMD_PUSH;
				state_d = S_FIN;
			end
			S_POP: begin
				cmd     = chgc_pkg::CMD_POP_RD;
				state_d = sts.rc_nz ? S_POPD : S_FIN;
			end
			S_POPD: begin
				cmd     = chgc_pkg::CMD_POP_DONE;
				state_d = S_FIN;
			end
			S_APICK: begin
				cmd = chgc_pkg::CMD_AL_PICK;
				priority if (sts.fc_nz) state_d = S_AFREE;
				else if (sts.cu_lt)     state_d = S_AWR;
				else                    state_d = S_FIN;
			end
			S_AFREE: begin
				cmd     = chgc_pkg::CMD_AL_FREE;
				state_d = S_AWR;
			end
			S_AWR: begin
				cmd     = chgc_pkg::CMD_AL_WRITE;
				state_d = S_APOST;
			end
			S_APOST: begin
				if (sts.full) begin
					has_new_d = 1'b1;
					post_d    = 1'b1;
					state_d   = S_GSTRT;
				end else begin
					state_d = S_FIN;
				end
			end
			S_GSTRT: begin
				cmd     = chgc_pkg::CMD_GC_START;
				state_d = S_GCLR;
			end
			S_GCLR: begin
				cmd = chgc_pkg::CMD_CLR;
				if (sts.i_last) begin
					if (has_new_q) begin
						vret_d  = S_GROOT;
						state_d = S_VRD;
					end else begin
						state_d = S_GROOT;
					end
				end
			end
			S_GROOT: begin
				priority if (sts.ovf) begin
					state_d = S_GEND;
				end else if (sts.j_lt_rc) begin
					cmd     = chgc_pkg::CMD_ROOT_RD;
					state_d = S_GRLD;
				end else begin
					state_d = S_TPOP;
				end
			end
			S_GRLD: begin
				cmd     = chgc_pkg::CMD_ROOT_LD;
				vret_d  = S_GROOT;
				state_d = S_VRD;
			end
			S_VRD: begin
				cmd     = chgc_pkg::CMD_V_RD;
				state_d = S_VACT;
			end
			S_VACT: begin
				cmd     = chgc_pkg::CMD_V_ACT;
				state_d = vret_q;
			end
			S_TPOP: begin
				priority if (sts.ovf) begin
					state_d = S_GEND;
				end else if (sts.wl_nz) begin
					cmd     = chgc_pkg::CMD_T_POP;
					state_d = S_TCELL;
				end else begin
					state_d = S_SRD;
				end
			end
			S_TCELL: begin
				cmd     = chgc_pkg::CMD_T_CELL;
				state_d = S_THEAD;
			end
			S_THEAD: begin
				cmd     = chgc_pkg::CMD_T_HEAD;
				vret_d  = S_TTAIL;
				state_d = S_VRD;
			end
			S_TTAIL: begin
				cmd     = chgc_pkg::CMD_T_TAIL;
				vret_d  = S_TPOP;
				state_d = S_VRD;
			end
			S_SRD: begin
				cmd     = chgc_pkg::CMD_S_RD;
				state_d = S_SACT;
			end
			S_SACT: begin
				cmd     = chgc_pkg::CMD_S_ACT;
				if (sts.i_last) state_d = S_GEND;
				else            state_d = S_SRD;
			end
			S_GEND: begin
				state_d = post_q ? S_FIN : S_APICK;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd     = chgc_pkg::CMD_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vret_q    <= S_IDLE;
			has_new_q <= 1'b0;
			post_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			vret_q    <= vret_d;
			has_new_q <= has_new_d;
			post_q    <= post_d;
		end
	end

endmodule

### rtl/chgc_dp.sv
`timescale 1ns / 1ps
module chgc_dp #(
	parameter int HEAP_DEPTH     = 256,
	parameter int ROOT_DEPTH     = 64,
	parameter int WORKLIST_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  chgc_pkg::in_t     in_data,
	input  chgc_pkg::cmd_t    cmd,
	output chgc_pkg::sts_t    sts,
	output logic              out_valid,
	input  logic              out_stall,
	output chgc_pkg::out_t    out_data
);

	localparam int IDXW = $clog2(HEAP_DEPTH);
	localparam int CNTW = $clog2(HEAP_DEPTH + 1);
	localparam int RIDX = (ROOT_DEPTH > 1) ? $clog2(ROOT_DEPTH) : 1;
	localparam int RCW  = $clog2(ROOT_DEPTH + 1);
	localparam int WIDX = $clog2(WORKLIST_DEPTH);
	localparam int WCW  = $clog2(WORKLIST_DEPTH + 1);

	logic [63:0]     cell_mem [HEAP_DEPTH];
	logic            mark_mem [HEAP_DEPTH];
	logic [IDXW-1:0] free_mem [HEAP_DEPTH];
	logic [31:0]     root_mem [ROOT_DEPTH];
	logic [IDXW-1:0] work_mem [WORKLIST_DEPTH];

	logic [63:0]     cell_rd_q;
	logic            mark_rd_q;
	logic [IDXW-1:0] free_rd_q;
	logic [31:0]     root_rd_q;
	logic [IDXW-1:0] work_rd_q;

	logic [CNTW-1:0] cu_q, fc_q;
	logic [RCW-1:0]  rc_q, j_q;
	logic [WCW-1:0]  wl_q;
	logic            ovf_q;
	logic [IDXW-1:0] i_q, ix_q;
	logic [31:0]     vw_q;
	logic            vlive_q;
	chgc_pkg::in_t   req_q;
	logic [31:0]     res_q;
	logic [1:0]      st_q;
	logic            out_valid_q;
	chgc_pkg::out_t  out_q;

	logic [CNTW-1:0] fc_dec;
	logic [RCW-1:0]  rc_dec;
	logic [WCW-1:0]  wl_dec;
	logic            ref_live, vw_live, wl_full;

	function automatic logic is_live(input logic [31:0] w, input logic [CNTW-1:0] used);
		is_live = (w[31:30] == chgc_pkg::PTR_TAG) && (w[29:0] < 30'(used));
	endfunction

	assign fc_dec   = fc_q - 1'b1;
	assign rc_dec   = rc_q - 1'b1;
	assign wl_dec   = wl_q - 1'b1;
	assign ref_live = is_live(req_q.ref_word, cu_q);
	assign vw_live  = is_live(vw_q, cu_q);
	assign wl_full  = (wl_q == WCW'(WORKLIST_DEPTH));

	assign sts.full     = (fc_q == '0) && (cu_q >= CNTW'(HEAP_DEPTH));
	assign sts.fc_nz    = (fc_q != '0);
	assign sts.cu_lt    = (cu_q < CNTW'(HEAP_DEPTH));
	assign sts.rc_nz    = (rc_q != '0);
	assign sts.j_lt_rc  = (j_q < rc_q);
	assign sts.i_last   = (i_q == IDXW'(HEAP_DEPTH - 1));
	assign sts.wl_nz    = (wl_q != '0);
	assign sts.ovf      = ovf_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd == chgc_pkg::CMD_AL_WRITE)
			cell_mem[ix_q] <= {req_q.head_word, req_q.tail_word};
		if (cmd == chgc_pkg::CMD_CAPTURE)
			cell_rd_q <= cell_mem[in_data.ref_word[IDXW-1:0]];
		else if (cmd == chgc_pkg::CMD_T_CELL)
			cell_rd_q <= cell_mem[work_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd == chgc_pkg::CMD_CLR)
			mark_mem[i_q] <= 1'b0;
		else if (cmd == chgc_pkg::CMD_V_ACT && vlive_q && !mark_rd_q && !wl_full)
			mark_mem[vw_q[IDXW-1:0]] <= 1'b1;
		if (cmd == chgc_pkg::CMD_V_RD)
			mark_rd_q <= mark_mem[vw_q[IDXW-1:0]];
		else if (cmd == chgc_pkg::CMD_S_RD)
			mark_rd_q <= mark_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (cmd == chgc_pkg::CMD_S_ACT && !mark_rd_q)
			free_mem[fc_q[IDXW-1:0]] <= i_q;
		if (cmd == chgc_pkg::CMD_AL_PICK && fc_q != '0)
			free_rd_q <= free_mem[fc_dec[IDXW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd == chgc_pkg::CMD_PUSH && rc_q < RCW'(ROOT_DEPTH))
			root_mem[rc_q[RIDX-1:0]] <= req_q.head_word;
		if (cmd == chgc_pkg::CMD_POP_RD && rc_q != '0)
			root_rd_q <= root_mem[rc_dec[RIDX-1:0]];
		else if (cmd == chgc_pkg::CMD_ROOT_RD)
			root_rd_q <= root_mem[j_q[RIDX-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd == chgc_pkg::CMD_V_ACT && vlive_q && !mark_rd_q && !wl_full)
			work_mem[wl_q[WIDX-1:0]] <= vw_q[IDXW-1:0];
		if (cmd == chgc_pkg::CMD_T_POP)
			work_rd_q <= work_mem[wl_dec[WIDX-1:0]];
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cu_q        <= '0;
			fc_q        <= '0;
			rc_q        <= '0;
			wl_q        <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				chgc_pkg::CMD_PUSH:
					if (rc_q < RCW'(ROOT_DEPTH)) rc_q <= rc_q + 1'b1;
				chgc_pkg::CMD_POP_RD:
					if (rc_q != '0) rc_q <= rc_dec;
				chgc_pkg::CMD_AL_PICK: begin
					priority if (fc_q != '0)               fc_q <= fc_dec;
					else if (cu_q < CNTW'(HEAP_DEPTH))     cu_q <= cu_q + 1'b1;
				end
				chgc_pkg::CMD_GC_START: begin
					wl_q  <= '0;
					ovf_q <= 1'b0;
				end
				chgc_pkg::CMD_V_ACT: begin
					if (vlive_q && !mark_rd_q) begin
						if (wl_full) ovf_q <= 1'b1;
						else         wl_q  <= wl_q + 1'b1;
					end
				end
				chgc_pkg::CMD_T_POP: wl_q <= wl_dec;
				chgc_pkg::CMD_S_ACT:
					if (!mark_rd_q) fc_q <= fc_q + 1'b1;
				default: ;
			endcase
			if (cmd == chgc_pkg::CMD_FIN)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			chgc_pkg::CMD_CAPTURE: req_q <= in_data;
			chgc_pkg::CMD_RD_DONE: begin
				res_q <= ref_live ? (req_q.which_half ? cell_rd_q[31:0] : cell_rd_q[63:32])
				                  : 32'd0;
				st_q  <= ref_live ? chgc_pkg::ST_OK : chgc_pkg::ST_BAD_ADDR;
			end
			chgc_pkg::CMD_PUSH: begin
				res_q <= 32'd0;
				st_q  <= (rc_q < RCW'(ROOT_DEPTH)) ? chgc_pkg::ST_OK : chgc_pkg::ST_ROOT_ERR;
			end
			chgc_pkg::CMD_POP_RD: begin
				res_q <= 32'd0;
				st_q  <= (rc_q != '0) ? chgc_pkg::ST_OK : chgc_pkg::ST_ROOT_ERR;
			end
			chgc_pkg::CMD_POP_DONE: res_q <= root_rd_q;
			chgc_pkg::CMD_AL_PICK: begin
				ix_q  <= cu_q[IDXW-1:0];
				res_q <= 32'd0;
				st_q  <= chgc_pkg::ST_EXHAUSTED;
			end
			chgc_pkg::CMD_AL_FREE: ix_q <= free_rd_q;
			chgc_pkg::CMD_AL_WRITE: begin
				res_q <= {chgc_pkg::PTR_TAG, 30'(ix_q)};
				st_q  <= chgc_pkg::ST_OK;
			end
			chgc_pkg::CMD_GC_START: begin
				vw_q <= res_q;
				i_q  <= '0;
				j_q  <= '0;
			end
			chgc_pkg::CMD_CLR, chgc_pkg::CMD_S_ACT:
				i_q <= (i_q == IDXW'(HEAP_DEPTH - 1)) ? '0 : i_q + 1'b1;
			chgc_pkg::CMD_ROOT_LD: begin
				vw_q <= root_rd_q;
				j_q  <= j_q + 1'b1;
			end
			chgc_pkg::CMD_V_RD:   vlive_q <= vw_live;
			chgc_pkg::CMD_T_HEAD: vw_q <= cell_rd_q[63:32];
			chgc_pkg::CMD_T_TAIL: vw_q <= cell_rd_q[31:0];
			chgc_pkg::CMD_FIN: begin
				out_q.result_word <= res_q;
				out_q.status      <= st_q;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_cu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cu_q <= CNTW'(HEAP_DEPTH)) else $error("cells_used past heap size");
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= cu_q) else $error("free count exceeds used cells");
	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= RCW'(ROOT_DEPTH)) else $error("root count past stack depth");
	a_wl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wl_q <= WCW'(WORKLIST_DEPTH)) else $error("worklist length past depth");
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == chgc_pkg::CMD_FIN |=> out_valid_q) else $error("result beat lost");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int HEAP_N = 256;
	localparam int ROOT_N = 64;
	localparam int WORK_N = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	chgc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	chgc_pkg::out_t out_data;

	cons_heap_mark_sweep_gc i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow heap
	logic [31:0] heap_head [HEAP_N];
	logic [31:0] heap_tail [HEAP_N];
	bit heap_mark [HEAP_N];
	int used_cnt;
	int free_list [HEAP_N];
	int free_cnt;
	logic [31:0] root_stack [ROOT_N];
	int root_cnt;
	int work_list [WORK_N];
	int work_cnt;
	bit work_ovf;

	chgc_pkg::out_t result_q [$];
	logic [31:0] live_ptrs [$];
	int errors = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	function automatic bit is_live(logic [31:0] w);
		return w[31:30] == chgc_pkg::PTR_TAG && w[29:0] < used_cnt;
	endfunction

	function automatic void mark_cell(logic [31:0] w);
		int ix;
		if (!is_live(w))
			return;
		ix = int'(w[29:0]);
		if (heap_mark[ix])
			return;
		if (work_cnt >= WORK_N) begin
			work_ovf = 1'b1;
			return;
		end
		heap_mark[ix] = 1'b1;
		work_list[work_cnt++] = ix;
	endfunction

	function automatic void collect_heap(bit has_new, logic [31:0] new_ptr);
		int ix;
		work_cnt = 0;
		work_ovf = 1'b0;
		if (has_new)
			mark_cell(new_ptr);
		for (int i = 0; i < root_cnt; i++)
			mark_cell(root_stack[i]);
		while (work_cnt > 0 && !work_ovf) begin
			ix = work_list[--work_cnt];
			mark_cell(heap_head[ix]);
			mark_cell(heap_tail[ix]);
		end
		if (!work_ovf) begin
			free_cnt = 0;
			for (int i = 0; i < used_cnt; i++)
				if (!heap_mark[i])
					free_list[free_cnt++] = i;
		end
		for (int i = 0; i < HEAP_N; i++)
			heap_mark[i] = 1'b0;
		work_cnt = 0;
	endfunction

	function automatic chgc_pkg::out_t heap_predict(chgc_pkg::in_t it);
		chgc_pkg::out_t r;
		int ix;
		bit got;
		r = '0;
		ix = 0;
		got = 1'b0;
		case (it.req_type)
			chgc_pkg::REQ_ALLOC: begin
				if (free_cnt == 0 && used_cnt >= HEAP_N)
					collect_heap(1'b0, '0);
				if (free_cnt > 0) begin
					ix = free_list[--free_cnt];
					got = 1'b1;
				end else if (used_cnt < HEAP_N) begin
					ix = used_cnt++;
					got = 1'b1;
				end
				if (got) begin
					heap_head[ix] = it.head_word;
					heap_tail[ix] = it.tail_word;
					r.result_word = {chgc_pkg::PTR_TAG, 30'(ix)};
					if (free_cnt == 0 && used_cnt >= HEAP_N)
						collect_heap(1'b1, r.result_word);
				end else begin
					r.status = chgc_pkg::ST_EXHAUSTED;
				end
			end
			chgc_pkg::REQ_READ: begin
				if (is_live(it.ref_word)) begin
					ix = int'(it.ref_word[29:0]);
					r.result_word = it.which_half ? heap_tail[ix] : heap_head[ix];
				end else begin
					r.status = chgc_pkg::ST_BAD_ADDR;
				end
			end
			chgc_pkg::REQ_PUSH: begin
				if (root_cnt < ROOT_N)
					root_stack[root_cnt++] = it.head_word;
				else
					r.status = chgc_pkg::ST_ROOT_ERR;
			end
			default: begin
				if (root_cnt > 0)
					r.result_word = root_stack[--root_cnt];
				else
					r.status = chgc_pkg::ST_ROOT_ERR;
			end
		endcase
		return r;
	endfunction

	function automatic chgc_pkg::in_t mk_req(logic [1:0] rq, logic [31:0] hw,
			logic [31:0] tw, logic [31:0] rw, logic hf);
		chgc_pkg::in_t it;
		it.req_type = rq;
		it.head_word = hw;
		it.tail_word = tw;
		it.ref_word = rw;
		it.which_half = hf;
		return it;
	endfunction

	// drive one beat, wait for acceptance, record the predicted result
	task automatic send_req(input chgc_pkg::in_t it, output chgc_pkg::out_t pred);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = heap_predict(it);
		result_q = {result_q, pred};
		if (it.req_type == chgc_pkg::REQ_ALLOC && pred.status == chgc_pkg::ST_OK)
			live_ptrs = {live_ptrs, pred.result_word};
	endtask

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_gap(input chgc_pkg::in_t it, output chgc_pkg::out_t pred);
		idle_gap();
		send_req(it, pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 19);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		chgc_pkg::out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, out_data);
				errors++;
			end else begin
				exp_r = result_q.pop_front();
				if (out_data.result_word !== exp_r.result_word) begin
					$display("%0t: result_word expected %h actual %h", $time,
						exp_r.result_word, out_data.result_word);
					errors++;
				end
				if (out_data.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						exp_r.status, out_data.status);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		chgc_pkg::out_t p, a0, a1;
		send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'h0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'h8000_0000, 1'b1), p);
		send_gap(mk_req(chgc_pkg::REQ_ALLOC, 32'h0, 32'hFFFF_FFFF, '0, 1'b0), a0);
		send_gap(mk_req(chgc_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'h0, '0, 1'b1), a1);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, a0.result_word, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, a0.result_word, 1'b1), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, a1.result_word, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			a1.result_word, 1'b1), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'hC000_0000, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'h4000_0001, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'h8000_0002, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, 32'hBFFF_FFFF, 1'b1), p);
		send_gap(mk_req(chgc_pkg::REQ_PUSH, 32'h0, '0, '0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_PUSH, 32'hFFFF_FFFF, '0, '0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
		send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
	endtask

	task automatic test_root_overflow();
		chgc_pkg::out_t p;
		for (int i = 0; i < ROOT_N + 2; i++)
			send_gap(mk_req(chgc_pkg::REQ_PUSH, $urandom, '0, '0, 1'b0), p);
		for (int i = 0; i < ROOT_N + 1; i++)
			send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
	endtask

	// a chain rooted at its newest cell grows until the heap is exhausted
	task automatic test_heap_exhaust();
		chgc_pkg::out_t p;
		logic [31:0] prev;
		int n_exh;
		prev = 32'h0;
		n_exh = 0;
		drain();
		send_req(mk_req(chgc_pkg::REQ_PUSH, 32'h0, '0, '0, 1'b0), p);
		for (int i = 0; i < 300 && n_exh < 2; i++) begin
			send_gap(mk_req(chgc_pkg::REQ_ALLOC, $urandom, prev, '0, 1'b0), p);
			if (p.status == chgc_pkg::ST_EXHAUSTED)
				n_exh++;
			else
				prev = p.result_word;
			// near full, keep the root on the newest cell
			if (i >= 250) begin
				send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
				send_gap(mk_req(chgc_pkg::REQ_PUSH, prev, '0, '0, 1'b0), p);
			end
		end
		send_gap(mk_req(chgc_pkg::REQ_READ, '0, '0, prev, 1'b1), p);
		send_gap(mk_req(chgc_pkg::REQ_POP, '0, '0, '0, 1'b0), p);
	endtask

	function automatic logic [31:0] rand_word();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4 && live_ptrs.size() != 0)
			return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
		if (k < 6)
			return {chgc_pkg::PTR_TAG, 30'($urandom_range(0, 300))};
		return $urandom;
	endfunction

	task automatic test_random(input int n_items);
		chgc_pkg::out_t p;
		int k;
		chgc_pkg::in_t it;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items - 20)
				quiet = 1'b1;
			k = $urandom_range(0, 9);
			it = mk_req(2'($urandom), rand_word(), rand_word(), rand_word(), 1'($urandom));
			if (k < 4)
				it.req_type = chgc_pkg::REQ_ALLOC;
			else if (k < 7)
				it.req_type = chgc_pkg::REQ_READ;
			else if (k < 8)
				it.req_type = chgc_pkg::REQ_PUSH;
			else if (k < 9)
				it.req_type = chgc_pkg::REQ_POP;
			send_gap(it, p);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_root_overflow();
		test_heap_exhaust();
		test_random(40);
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
